>>> hdl/nsvl_pkg.sv
// Shared types and codes for the nearest-seed Voronoi labeler.
`timescale 1ns / 1ps

package nsvl_pkg;

  // Input command codes.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  // Grid size registers and their reset value.
  localparam int GRID_W = 13;
  localparam logic [GRID_W-1:0] GRID_RESET = 13'd4096;

  // Squared distance: two 34-bit squares and their sum.
  localparam int SQ_W   = 34;
  localparam int DIST_W = SQ_W + 1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // a load transfer is accepted
    logic query;    // a query transfer is accepted
    logic scan_rd;  // read the next seed and advance the scan address
    logic finish;   // move the query result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic early_err;  // the query on the input gives an error status
    logic last_addr;  // the scan address points at the last stored seed
    logic pipe_busy;  // seeds are still in the distance pipeline
    logic out_free;   // the output register can take a result this cycle
  } dp_stat_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

endpackage

>>> hdl/nsvl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module nsvl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/nsvl_dp.sv
// Datapath: seed store, grid registers, distance pipeline, best tracker, output register.
`timescale 1ns / 1ps

module nsvl_dp #(
  parameter int MAX_SEEDS = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [nsvl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nsvl_pkg::GRID_W-1:0]      cfg_data,
  input  logic                             first_seed,
  input  logic signed [15:0]               seed_x,
  input  logic signed [15:0]               seed_y,
  input  logic [11:0]                      cell_x,
  input  logic [11:0]                      cell_y,
  input  nsvl_pkg::dp_cmd_t                cmd,
  output nsvl_pkg::dp_stat_t               stat,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [7:0]                       nearest_index,
  output logic [1:0]                       status,
  output logic                             seeds_dropped
);

  import nsvl_pkg::*;

  localparam int IDX_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CNT_W = $clog2(MAX_SEEDS + 1);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_SEEDS);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  logic [GRID_W-1:0] grid_width;
  logic [GRID_W-1:0] grid_height;
  logic [CNT_W-1:0]  seed_count;
  logic              overflow;

  logic [15:0]       cx;
  logic [15:0]       cy;
  logic [1:0]        q_status;
  logic [IDX_W-1:0]  addr;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [31:0]       ram_rdata;

  logic              v1, v2, v3;
  logic [IDX_W-1:0]  idx1, idx2, idx3;
  logic signed [17:0] dx, dy;
  logic signed [35:0] prod_x, prod_y;
  logic [SQ_W-1:0]   sq_x, sq_y;
  logic [DIST_W-1:0] cur_d;
  logic [DIST_W-1:0] best_d;
  logic [IDX_W-1:0]  best_i;
  logic [IDX_W+7:0]  best_ext;

  logic              out_of_grid;
  logic [1:0]        q_status_in;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_RESET;
      grid_height <= GRID_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
      endcase
    end
  end

  // Seed loading: a first seed restarts the set, a full store drops the seed.
  assign ram_we    = cmd.load && (first_seed || (seed_count < MAX_C));
  assign ram_waddr = first_seed ? '0 : seed_count[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_count <= '0;
      overflow   <= 1'b0;
    end else if (cmd.load) begin
      if (first_seed) begin
        seed_count <= ONE_C;
        overflow   <= 1'b0;
      end else if (seed_count < MAX_C) begin
        seed_count <= seed_count + ONE_C;
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  nsvl_ram #(
    .WIDTH(32),
    .DEPTH(MAX_SEEDS)
  ) u_seed_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data({seed_x, seed_y}),
    .rd_en  (cmd.scan_rd),
    .rd_addr(addr),
    .rd_data(ram_rdata)
  );

  // Query check: the grid range takes precedence over the empty store.
  assign out_of_grid = ({1'b0, cell_x} >= grid_width) || ({1'b0, cell_y} >= grid_height);
  assign q_status_in = out_of_grid ? ST_RANGE :
                       (seed_count == '0) ? ST_EMPTY : ST_OK;

  // Query capture and scan address. The cell center is cell * 16 + 8.
  always_ff @(posedge clk) begin
    if (cmd.query) begin
      cx       <= {cell_x, 4'b1000};
      cy       <= {cell_y, 4'b1000};
      q_status <= q_status_in;
      addr     <= '0;
    end else if (cmd.scan_rd) begin
      addr <= addr + 1'b1;
    end
  end

  // Pipeline valid tags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.scan_rd;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 1 index follows the RAM read; stage 2 takes the differences.
  always_ff @(posedge clk) begin
    idx1 <= addr;
    idx2 <= idx1;
    idx3 <= idx2;
    dx   <= $signed({2'b00, cx}) - $signed({{2{ram_rdata[31]}}, ram_rdata[31:16]});
    dy   <= $signed({2'b00, cy}) - $signed({{2{ram_rdata[15]}}, ram_rdata[15:0]});
  end

  // Stage 3: squares, each below 2^34.
  assign prod_x = dx * dx;
  assign prod_y = dy * dy;

  always_ff @(posedge clk) begin
    sq_x <= prod_x[SQ_W-1:0];
    sq_y <= prod_y[SQ_W-1:0];
  end

  // Stage 4: sum and keep the first strictly smaller distance.
  assign cur_d = {1'b0, sq_x} + {1'b0, sq_y};

  always_ff @(posedge clk) begin
    if (v3 && ((idx3 == '0) || (cur_d < best_d))) begin
      best_d <= cur_d;
      best_i <= idx3;
    end
  end

  // Output register.
  assign best_ext = {8'b0, best_i};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      nearest_index <= (q_status == ST_OK) ? best_ext[7:0] : 8'd0;
      status        <= q_status;
      seeds_dropped <= overflow;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.early_err = (q_status_in != ST_OK);
    stat.last_addr = (CNT_W'(addr) == (seed_count - ONE_C));
    stat.pipe_busy = v1 || v2 || v3;
    stat.out_free  = !out_valid || !out_stall;
  end

endmodule

>>> hdl/nsvl_ctrl.sv
// Controller: sequences the input transfer, seed scan, pipeline drain and result hand-off.
`timescale 1ns / 1ps

module nsvl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                command,
  output logic                in_stall,
  input  nsvl_pkg::dp_stat_t  stat,
  output nsvl_pkg::dp_cmd_t   cmd
);

  import nsvl_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Next state and datapath commands.
  always_comb begin
    state_next  = state;
    cmd.load    = accept && (command == CMD_LOAD);
    cmd.query   = accept && (command == CMD_QUERY);
    cmd.scan_rd = 1'b0;
    cmd.finish  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd.query) begin
          state_next = stat.early_err ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.last_addr) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/nearest_seed_voronoi_label.sv
// Top level of the nearest-seed Voronoi labeler.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_stall    command, first_seed, seed_x, seed_y,
//                                              cell_x, cell_y
//   out      output     out_valid / out_stall  nearest_index, status, seeds_dropped
//   cfg      input      cfg_write              cfg_index, cfg_data
//
// A load gives no result. A valid query reads one seed from the seed RAM per
// cycle and then lets the distance pipeline drain. A query with an error status
// skips the seed scan and goes straight to the hand-off.
// Reset clears the seed count, the overflow flag and the handshake state and sets
// both grid sizes to 4096. A stalled result waits in the output register; loads
// are still taken meanwhile, and the next query stalls only at its hand-off.
`timescale 1ns / 1ps

module nearest_seed_voronoi_label #(
  parameter int MAX_SEEDS = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [nsvl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nsvl_pkg::GRID_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            command,
  input  logic                            first_seed,
  input  logic signed [15:0]              seed_x,
  input  logic signed [15:0]              seed_y,
  input  logic [11:0]                     cell_x,
  input  logic [11:0]                     cell_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      nearest_index,
  output logic [1:0]                      status,
  output logic                            seeds_dropped
);

  import nsvl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Control.
  nsvl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .command (command),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Datapath.
  nsvl_dp #(
    .MAX_SEEDS(MAX_SEEDS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .first_seed   (first_seed),
    .seed_x       (seed_x),
    .seed_y       (seed_y),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .cmd          (cmd),
    .stat         (stat),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .nearest_index(nearest_index),
    .status       (status),
    .seeds_dropped(seeds_dropped)
  );

endmodule

>>> bench/nearest_seed_voronoi_label_test.sv
// Self-checking testbench for the nearest-seed Voronoi labeler.
`timescale 1ns / 1ps

import nsvl_pkg::*;

localparam int SEED_SLOTS = 256;

// One input transfer: a seed load or a cell query.
typedef struct {
  logic               command;
  logic               first_seed;
  logic signed [15:0] seed_x;
  logic signed [15:0] seed_y;
  logic [11:0]        cell_x;
  logic [11:0]        cell_y;
} grid_item_t;

// One labeling result.
typedef struct {
  logic [7:0] nearest_index;
  logic [1:0] status;
  logic       seeds_dropped;
} cell_label_t;

// Keeps its own copy of the seed set and grid size and predicts each label.
class label_predictor;
  logic signed [15:0] seed_xs [SEED_SLOTS];
  logic signed [15:0] seed_ys [SEED_SLOTS];
  int unsigned        seed_total;
  logic               overflow;
  logic [GRID_W-1:0]  grid_w;
  logic [GRID_W-1:0]  grid_h;
  cell_label_t        labels_due [$];
  int unsigned        mismatches;

  function new();
    seed_total = 0;
    overflow = 1'b0;
    grid_w = GRID_RESET;
    grid_h = GRID_RESET;
    mismatches = 0;
  endfunction

  // Track a grid size register write.
  function void write_reg(input logic [CFG_IDX_W-1:0] index, input logic [GRID_W-1:0] value);
    if (index == REG_GRID_WIDTH) begin
      grid_w = value;
    end else begin
      grid_h = value;
    end
  endfunction

  // Apply an accepted transfer; a query queues the label it should produce.
  function void take_item(input grid_item_t item);
    cell_label_t lbl;
    longint      cx;
    longint      cy;
    longint      dx;
    longint      dy;
    longint      d;
    longint      best_d;
    int unsigned best;
    int unsigned i;
    if (item.command == CMD_LOAD) begin
      if (item.first_seed) begin
        seed_total = 0;
        overflow = 1'b0;
      end
      if (seed_total < SEED_SLOTS) begin
        seed_xs[seed_total] = item.seed_x;
        seed_ys[seed_total] = item.seed_y;
        seed_total++;
      end else begin
        overflow = 1'b1;
      end
      return;
    end
    lbl.nearest_index = '0;
    lbl.status = ST_OK;
    lbl.seeds_dropped = overflow;
    // The grid check wins over the empty-store check.
    if (item.cell_x >= grid_w || item.cell_y >= grid_h) begin
      lbl.status = ST_RANGE;
    end else if (seed_total == 0) begin
      lbl.status = ST_EMPTY;
    end else begin
      // Cell center in the seed format: x*16+8, y*16+8. Ties keep the lower index.
      cx = longint'(item.cell_x) * 16 + 8;
      cy = longint'(item.cell_y) * 16 + 8;
      best = 0;
      best_d = 0;
      for (i = 0; i < seed_total; i++) begin
        dx = cx - longint'(seed_xs[i]);
        dy = cy - longint'(seed_ys[i]);
        d = dx * dx + dy * dy;
        if (i == 0 || d < best_d) begin
          best_d = d;
          best = i;
        end
      end
      lbl.nearest_index = best[7:0];
    end
    labels_due.push_back(lbl);
  endfunction

  // Compare a label from the block with the oldest one outstanding.
  function void check_label(input cell_label_t got);
    cell_label_t want;
    if (labels_due.size() == 0) begin
      $display("%0t: label with no query outstanding: index %0d status %0d dropped %0b",
               $time, got.nearest_index, got.status, got.seeds_dropped);
      mismatches++;
      return;
    end
    want = labels_due.pop_front();
    if (got.nearest_index !== want.nearest_index) begin
      $display("%0t: nearest_index expected %0d actual %0d",
               $time, want.nearest_index, got.nearest_index);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      mismatches++;
    end
    if (got.seeds_dropped !== want.seeds_dropped) begin
      $display("%0t: seeds_dropped expected %0b actual %0b",
               $time, want.seeds_dropped, got.seeds_dropped);
      mismatches++;
    end
  endfunction
endclass

module nearest_seed_voronoi_label_test;

  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam int unsigned IDLE_PCT    = 29;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_WIDTH;
  logic [GRID_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 command = CMD_LOAD;
  logic                 first_seed = 1'b0;
  logic signed [15:0]   seed_x = '0;
  logic signed [15:0]   seed_y = '0;
  logic [11:0]          cell_x = '0;
  logic [11:0]          cell_y = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           nearest_index;
  logic [1:0]           status;
  logic                 seeds_dropped;

  label_predictor       predictor = new();
  int unsigned          cycle_count = 0;
  int unsigned          items_sent = 0;
  int unsigned          send_idle_pct = IDLE_PCT;
  int unsigned          recv_idle_pct = IDLE_PCT;
  int unsigned          hold_request = 0;
  logic signed [15:0]   last_x = '0;
  logic signed [15:0]   last_y = '0;

  nearest_seed_voronoi_label #(
    .MAX_SEEDS(SEED_SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .first_seed(first_seed),
    .seed_x(seed_x),
    .seed_y(seed_y),
    .cell_x(cell_x),
    .cell_y(cell_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .nearest_index(nearest_index),
    .status(status),
    .seeds_dropped(seeds_dropped)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("nearest_seed_voronoi_label regression: fail");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the stall for the next cycle.
  initial begin : receiver
    int unsigned hold_left;
    cell_label_t got;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.nearest_index = nearest_index;
        got.status = status;
        got.seeds_dropped = seeds_dropped;
        predictor.check_label(got);
      end
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Cells that stimulus treats as inside the grid along one axis.
  function automatic int unsigned cells_in_use(input logic [GRID_W-1:0] cells);
    if (cells == 0) return 1;
    if (cells > 4096) return 4096;
    return 32'(cells);
  endfunction

  // A seed load: mostly inside the grid, some anywhere, some repeating the last seed.
  function automatic grid_item_t make_load(input logic first);
    grid_item_t  item;
    int unsigned pick;
    int unsigned lim_x;
    int unsigned lim_y;
    item.command = CMD_LOAD;
    item.first_seed = first;
    item.cell_x = 12'($urandom);
    item.cell_y = 12'($urandom);
    lim_x = cells_in_use(predictor.grid_w) * 16;
    lim_y = cells_in_use(predictor.grid_h) * 16;
    if (lim_x > 32768) lim_x = 32768;
    if (lim_y > 32768) lim_y = 32768;
    pick = $urandom_range(99);
    if (pick < 60) begin
      item.seed_x = 16'($urandom_range(lim_x - 1));
      item.seed_y = 16'($urandom_range(lim_y - 1));
    end else if (pick < 85) begin
      item.seed_x = 16'($urandom);
      item.seed_y = 16'($urandom);
    end else begin
      item.seed_x = last_x;
      item.seed_y = last_y;
    end
    last_x = item.seed_x;
    last_y = item.seed_y;
    return item;
  endfunction

  // A cell query: mostly inside the grid, some at the corners, past the edge or anywhere.
  function automatic grid_item_t make_query();
    grid_item_t  item;
    int unsigned pick;
    int unsigned span_x;
    int unsigned span_y;
    item.command = CMD_QUERY;
    item.first_seed = 1'($urandom);
    item.seed_x = 16'($urandom);
    item.seed_y = 16'($urandom);
    span_x = cells_in_use(predictor.grid_w);
    span_y = cells_in_use(predictor.grid_h);
    pick = $urandom_range(99);
    if (pick < 70) begin
      item.cell_x = 12'($urandom_range(span_x - 1));
      item.cell_y = 12'($urandom_range(span_y - 1));
    end else if (pick < 80) begin
      item.cell_x = $urandom_range(1) ? 12'hFFF : 12'h000;
      item.cell_y = $urandom_range(1) ? 12'hFFF : 12'h000;
    end else if (pick < 85) begin
      item.cell_x = 12'((span_x < 4096) ? span_x : 4095);
      item.cell_y = 12'($urandom_range(span_y - 1));
    end else begin
      item.cell_x = 12'($urandom);
      item.cell_y = 12'($urandom);
    end
    return item;
  endfunction

  function automatic grid_item_t seed_at(input logic first, input logic signed [15:0] x,
                                         input logic signed [15:0] y);
    grid_item_t item;
    item = make_load(first);
    item.seed_x = x;
    item.seed_y = y;
    return item;
  endfunction

  function automatic grid_item_t cell_at(input logic [11:0] x, input logic [11:0] y);
    grid_item_t item;
    item = make_query();
    item.cell_x = x;
    item.cell_y = y;
    return item;
  endfunction

  // Offer one item, idling at random first, and hold it until the transfer.
  task automatic send_item(input grid_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= item.command;
    first_seed <= item.first_seed;
    seed_x <= item.seed_x;
    seed_y <= item.seed_y;
    cell_x <= item.cell_x;
    cell_y <= item.cell_y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predictor.take_item(item);
    items_sent++;
  endtask

  // Stop offering until every label has come back, then let a trailing load settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (predictor.labels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write both grid registers on back-to-back cycles.
  task automatic write_grid(input logic [GRID_W-1:0] w, input logic [GRID_W-1:0] h);
    cfg_write <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    predictor.write_reg(REG_GRID_WIDTH, w);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    predictor.write_reg(REG_GRID_HEIGHT, h);
    cfg_write <= 1'b0;
  endtask

  // Corner cases of the labeler, starting from an empty store.
  task automatic directed();
    send_item(cell_at(12'h000, 12'h000));
    send_item(cell_at(12'hFFF, 12'hFFF));
    send_item(seed_at(1'b1, 16'sh8000, 16'sh8000));
    send_item(seed_at(1'b0, 16'sh7FFF, 16'sh7FFF));
    send_item(cell_at(12'h000, 12'h000));
    send_item(cell_at(12'hFFF, 12'hFFF));
    // A seed on the center of cell (0,0), then an exact copy: the lower index wins.
    send_item(seed_at(1'b0, 16'sd8, 16'sd8));
    send_item(seed_at(1'b0, 16'sd8, 16'sd8));
    send_item(cell_at(12'd0, 12'd0));
    // Two seeds at equal distance on either side of the center of cell (1,0).
    send_item(seed_at(1'b0, 16'sd16, 16'sd8));
    send_item(seed_at(1'b0, 16'sd32, 16'sd8));
    send_item(cell_at(12'd1, 12'd0));
    // A first seed starts a new set.
    send_item(seed_at(1'b1, 16'sd100, -16'sd5));
    send_item(cell_at(12'd6, 12'd0));
    send_item(seed_at(1'b0, 16'sh5555, 16'shAAAA));
    send_item(seed_at(1'b0, 16'shAAAA, 16'sh5555));
    send_item(cell_at(12'hAAA, 12'h555));
    send_item(cell_at(12'h555, 12'hAAA));
  endtask

  // Fill the store to capacity, query it, then overflow it and query again.
  task automatic fill_store();
    grid_item_t  probe;
    int unsigned n;
    send_item(make_load(1'b1));
    repeat (SEED_SLOTS - 2) send_item(make_load(1'b0));
    // The last slot sits on the center of cell (250,250).
    send_item(seed_at(1'b0, 16'sd4008, 16'sd4008));
    probe = cell_at(12'd250, 12'd250);
    send_item(probe);
    repeat (2) send_item(make_query());
    n = $urandom_range(1, 8);
    repeat (n) send_item(make_load(1'b0));
    repeat (3) send_item(make_query());
  endtask

  // Random seed sets with queries, mixed with unstructured traffic.
  task automatic run_sets(input int unsigned count);
    int unsigned stop_at;
    int unsigned n;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        send_item(make_load($urandom_range(9) != 0));
        n = $urandom_range(15);
        repeat (n) send_item(make_load(1'b0));
        n = $urandom_range(1, 8);
        repeat (n) send_item(make_query());
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_item($urandom_range(1) ? make_query() : make_load($urandom_range(3) == 0));
        end
      end
    end
  endtask

  // Reset, directed items, then random phases under several grid sizes.
  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed();
    wait_drained();
    write_grid(13'd64, 13'd48);
    run_sets(120);
    wait_drained();
    write_grid(13'd4096, 13'd4096);
    fill_store();
    run_sets(60);
    wait_drained();
    write_grid(13'd1, 13'd1);
    run_sets(60);
    wait_drained();
    write_grid(13'd8191, 13'd8191);
    run_sets(80);
    wait_drained();
    write_grid(13'd0, 13'd8191);
    run_sets(40);
    wait_drained();
    write_grid(13'd4096, 13'd1);
    run_sets(40);
    wait_drained();
    write_grid(13'd8191, 13'd0);
    run_sets(30);
    // No idling on either side for a whole phase.
    wait_drained();
    write_grid(13'($urandom_range(1, 300)), 13'($urandom_range(1, 300)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_sets(120);
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;
    // The result side holds off long enough for queries to back up into the input.
    wait_drained();
    write_grid(13'd200, 13'd200);
    hold_request = 400;
    run_sets(100);
    in_valid <= 1'b0;
    while (predictor.labels_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (predictor.mismatches == 0) begin
      $display("nearest_seed_voronoi_label regression: pass");
    end else begin
      $display("nearest_seed_voronoi_label regression: fail");
    end
    $finish;
  end

endmodule
